// ===== design/dfms_pkg.sv =====
// Shared constants and types for the decimal floating-point magnitude subtractor.
// Holds default parameter values, stream field layout and BCD constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dfms_pkg;

    // Default sizes of the significand and the exponent.
    localparam int DIGITS_DEF   = 16;
    localparam int EXP_BITS_DEF = 16;

    // Fixed widths of the stream fields.
    localparam int DIGITS_W = 64;
    localparam int EXP_W    = 16;

    // Input word layout, lowest bit first.
    localparam int MIN_DIG_LSB = 0;
    localparam int MIN_EXP_LSB = MIN_DIG_LSB + DIGITS_W;
    localparam int SUB_DIG_LSB = MIN_EXP_LSB + EXP_W;
    localparam int SUB_EXP_LSB = SUB_DIG_LSB + DIGITS_W;
    localparam int S_TDATA_W   = SUB_EXP_LSB + EXP_W;

    // Output word layout.
    localparam int M_TDATA_W = DIGITS_W + EXP_W;
    localparam int M_TUSER_W = 3;

    // BCD constants.
    localparam logic [3:0] BCD_MAX    = 4'd9;
    localparam logic [3:0] ROUND_HALF = 4'd5;
    localparam logic [4:0] BCD_RADIX  = 5'd10;

    // Status flags carried beside each result, result_zero in the lowest bit.
    typedef struct packed {
        logic order_error;
        logic exp_underflow;
        logic result_zero;
    } dfms_flags_t;

endpackage

`default_nettype wire

// ===== design/dfms_round.sv =====
// Half-up rounding of a normalized BCD significand with one guard digit.
// Depends on dfms_pkg for the BCD constants.
`timescale 1ns / 1ps
`default_nettype none

module dfms_round
    import dfms_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEF
) (
    input  wire logic [(DIGITS+1)*4-1:0] norm_digits,    // kept digits with the guard digit in the lowest nibble
    output logic      [DIGITS*4-1:0]     rounded_digits,
    output logic                         round_carry
);

    logic [3:0]        guard;
    logic              round_up;
    logic [DIGITS-1:0] nine;
    logic [DIGITS-1:0] carry_in;

    assign guard    = norm_digits[3:0];
    assign round_up = (guard >= ROUND_HALF);

    // When the guard digit rounds up, a digit receives the increment when every digit below it is nine.
    always_comb begin
        logic [DIGITS-1:0] low_mask;
        logic [3:0]        dig;
        for (int j = 0; j < DIGITS; j++) begin
            nine[j] = (norm_digits[4*(j+1) +: 4] == BCD_MAX);
        end
        for (int j = 0; j < DIGITS; j++) begin
            for (int k = 0; k < DIGITS; k++) begin
                low_mask[k] = (k < j);
            end
            carry_in[j] = round_up && (&(nine | ~low_mask));
        end
        round_carry = round_up && (&nine);
        for (int j = 0; j < DIGITS; j++) begin
            dig = norm_digits[4*(j+1) +: 4];
            if (!carry_in[j]) begin
                rounded_digits[4*j +: 4] = dig;
            end else if (dig == BCD_MAX) begin
                rounded_digits[4*j +: 4] = 4'd0;
            end else begin
                rounded_digits[4*j +: 4] = dig + 4'd1;
            end
        end
        // Carry out of the top digit renormalizes to one followed by zeros.
        if (round_carry) begin
            rounded_digits[DIGITS*4-1 -: 4] = 4'd1;
        end
    end

endmodule

`default_nettype wire

// ===== design/decimal_float_magnitude_subtract.sv =====
// An accepted input word moves through the pipeline stages in order to the result word on m_axis.
// Throughput: one word per cycle; every stage holds its own valid bit, and a stage
// takes a new word whenever it is empty or its successor moves, so stalls lose nothing.
// The slowest step is the 2*DIGITS wide borrow prefix add in stage three.
// Reset (aresetn low, synchronous) clears all valid bits; data registers are not reset.
// Depends on dfms_pkg and dfms_round.
`timescale 1ns / 1ps
`default_nettype none

module decimal_float_magnitude_subtract
    import dfms_pkg::*;
#(
    parameter int DIGITS   = DIGITS_DEF,
    parameter int EXP_BITS = EXP_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // Fields from bit 0: minuend_digits, minuend_exp, subtrahend_digits, subtrahend_exp.
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,

    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // Fields from bit 0: difference_digits, difference_exp.
    output logic      [M_TDATA_W-1:0] m_axis_tdata,
    // Fields from bit 0: result_zero, exp_underflow, order_error.
    output logic      [M_TUSER_W-1:0] m_axis_tuser
);

    // The significand occupies DW bits; the aligned and subtracted buffers are twice as
    // wide. Shift and leading-zero counts run from zero up to WIDE inclusive.
    localparam int WIDE  = 2 * DIGITS;
    localparam int DW    = DIGITS * 4;
    localparam int WW    = WIDE * 4;
    localparam int NW    = (DIGITS + 1) * 4;
    localparam int SHW   = $clog2(WIDE + 1);
    localparam int CW    = (EXP_BITS > SHW) ? EXP_BITS : SHW;
    localparam int NSTG  = 7;
    localparam logic [EXP_BITS-1:0] EXP_MAX = {EXP_BITS{1'b1}};

    // Handshake: a stage advances when it is empty or the stage after it advances.
    logic [NSTG-1:0] vld_reg;
    logic [NSTG:0]   adv;

    always_comb begin
        adv[NSTG] = m_axis_tready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign s_axis_tready = adv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (adv[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Stage 1: unpack, clamp non-BCD nibbles to nine, and find the alignment shift.
    // A larger subtrahend exponent or a shift of WIDE digits or more flushes the
    // subtrahend to zero.
    logic [DW-1:0]       p1_a_next, p1_b_next;
    logic [EXP_BITS-1:0] ea, eb, ediff;
    logic                flush;
    logic [SHW-1:0]      p1_shift_next;
    logic [DW-1:0]       p1_a_reg, p1_b_reg;
    logic [SHW-1:0]      p1_shift_reg;
    logic [EXP_BITS-1:0] p1_exp_reg;

    always_comb begin
        logic [3:0] nib_a, nib_b;
        for (int j = 0; j < DIGITS; j++) begin
            nib_a = s_axis_tdata[MIN_DIG_LSB + 4*j +: 4];
            nib_b = s_axis_tdata[SUB_DIG_LSB + 4*j +: 4];
            p1_a_next[4*j +: 4] = (nib_a > BCD_MAX) ? BCD_MAX : nib_a;
            p1_b_next[4*j +: 4] = (nib_b > BCD_MAX) ? BCD_MAX : nib_b;
        end
    end

    assign ea    = EXP_BITS'(s_axis_tdata[MIN_EXP_LSB +: EXP_W]);
    assign eb    = EXP_BITS'(s_axis_tdata[SUB_EXP_LSB +: EXP_W]);
    assign ediff = ea - eb;
    assign flush = (eb > ea) || (CW'(ediff) >= CW'(WIDE));
    assign p1_shift_next = flush ? SHW'(WIDE) : SHW'(ediff);

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            p1_a_reg     <= p1_a_next;
            p1_b_reg     <= p1_b_next;
            p1_shift_reg <= p1_shift_next;
            p1_exp_reg   <= ea;
        end
    end

    // Stage 2: shift the subtrahend right into the double-width buffer.
    logic [WW-1:0]       p2_t_next;
    logic [DW-1:0]       p2_a_reg;
    logic [WW-1:0]       p2_t_reg;
    logic [EXP_BITS-1:0] p2_exp_reg;

    assign p2_t_next = {p1_b_reg, {DW{1'b0}}} >> {p1_shift_reg, 2'b00};

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            p2_a_reg   <= p1_a_reg;
            p2_t_reg   <= p2_t_next;
            p2_exp_reg <= p1_exp_reg;
        end
    end

    // Stage 3: resolve the borrow into every digit with one binary add. A digit
    // generates a borrow when the minuend digit is smaller and passes one along when
    // the digits are equal; carries of G + (G|P) are exactly those borrows.
    logic [WW-1:0]       p2_a_wide;
    logic [WIDE-1:0]     dig_gen, dig_prop;
    logic [WIDE:0]       bsum, bcarry;
    logic [WW-1:0]       p3_a_reg, p3_t_reg;
    logic [WIDE-1:0]     p3_bin_reg;
    logic                p3_borrow_reg;
    logic [EXP_BITS-1:0] p3_exp_reg;

    assign p2_a_wide = {p2_a_reg, {DW{1'b0}}};

    always_comb begin
        for (int j = 0; j < WIDE; j++) begin
            dig_gen[j]  = (p2_a_wide[4*j +: 4] <  p2_t_reg[4*j +: 4]);
            dig_prop[j] = (p2_a_wide[4*j +: 4] == p2_t_reg[4*j +: 4]);
        end
    end

    assign bsum   = {1'b0, dig_gen} + {1'b0, dig_gen | dig_prop};
    assign bcarry = bsum ^ {1'b0, dig_gen} ^ {1'b0, dig_gen | dig_prop};

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            p3_a_reg      <= p2_a_wide;
            p3_t_reg      <= p2_t_reg;
            p3_bin_reg    <= bcarry[WIDE-1:0];
            p3_borrow_reg <= bcarry[WIDE];
            p3_exp_reg    <= p2_exp_reg;
        end
    end

    // Stage 4: form each difference digit, wrapping negative values by adding ten.
    logic [WW-1:0]       p4_s_next;
    logic [WW-1:0]       p4_s_reg;
    logic                p4_borrow_reg;
    logic [EXP_BITS-1:0] p4_exp_reg;

    always_comb begin
        logic [4:0] d5;
        for (int j = 0; j < WIDE; j++) begin
            d5 = {1'b0, p3_a_reg[4*j +: 4]} - {1'b0, p3_t_reg[4*j +: 4]}
               - {4'b0000, p3_bin_reg[j]};
            p4_s_next[4*j +: 4] = d5[4] ? 4'(d5 + BCD_RADIX) : d5[3:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            p4_s_reg      <= p4_s_next;
            p4_borrow_reg <= p3_borrow_reg;
            p4_exp_reg    <= p3_exp_reg;
        end
    end

    // Stage 5: count leading zero digits and lower the exponent, saturating at zero.
    logic [SHW-1:0]      p5_lead_next;
    logic                p5_uflow_next;
    logic [EXP_BITS-1:0] p5_exp_next;
    logic [WW-1:0]       p5_s_reg;
    logic [SHW-1:0]      p5_lead_reg;
    logic [EXP_BITS-1:0] p5_exp_reg;
    logic                p5_uflow_reg, p5_zero_reg, p5_borrow_reg;

    always_comb begin
        p5_lead_next = SHW'(WIDE);
        for (int j = 0; j < WIDE; j++) begin
            if (p4_s_reg[4*j +: 4] != 4'd0) begin
                p5_lead_next = SHW'(WIDE - 1 - j);
            end
        end
    end

    assign p5_uflow_next = (CW'(p4_exp_reg) < CW'(p5_lead_next));
    assign p5_exp_next   = p5_uflow_next ? '0 : (p4_exp_reg - EXP_BITS'(p5_lead_next));

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            p5_s_reg      <= p4_s_reg;
            p5_lead_reg   <= p5_lead_next;
            p5_exp_reg    <= p5_exp_next;
            p5_uflow_reg  <= p5_uflow_next;
            p5_zero_reg   <= (p5_lead_next == SHW'(WIDE));
            p5_borrow_reg <= p4_borrow_reg;
        end
    end

    // Stage 6: normalize; keep the result digits and the guard digit below them.
    logic [WW-1:0]       norm_full;
    logic [NW-1:0]       p6_norm_reg;
    logic [EXP_BITS-1:0] p6_exp_reg;
    dfms_flags_t         p6_flags_reg;

    assign norm_full = p5_s_reg << {p5_lead_reg, 2'b00};

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            p6_norm_reg                <= norm_full[WW-1 -: NW];
            p6_exp_reg                 <= p5_exp_reg;
            p6_flags_reg.result_zero   <= p5_zero_reg;
            p6_flags_reg.exp_underflow <= p5_uflow_reg && !p5_zero_reg;
            p6_flags_reg.order_error   <= p5_borrow_reg;
        end
    end

    // Stage 7: round half-up into the output register. A carry out of the top digit
    // raises the exponent, saturating at its maximum. A zero result reports exponent 0.
    logic [DW-1:0]       rounded;
    logic                rcarry;
    logic [EXP_BITS-1:0] out_exp_next;
    logic [DW-1:0]       out_digits_reg;
    logic [EXP_BITS-1:0] out_exp_reg;
    dfms_flags_t         out_flags_reg;

    dfms_round #(
        .DIGITS (DIGITS)
    ) u_round (
        .norm_digits    (p6_norm_reg),
        .rounded_digits (rounded),
        .round_carry    (rcarry)
    );

    always_comb begin
        if (p6_flags_reg.result_zero) begin
            out_exp_next = '0;
        end else if (rcarry && (p6_exp_reg != EXP_MAX)) begin
            out_exp_next = p6_exp_reg + EXP_BITS'(1);
        end else begin
            out_exp_next = p6_exp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[6]) begin
            out_digits_reg <= p6_flags_reg.result_zero ? '0 : rounded;
            out_exp_reg    <= out_exp_next;
            out_flags_reg  <= p6_flags_reg;
        end
    end

    assign m_axis_tvalid                     = vld_reg[NSTG-1];
    assign m_axis_tdata[DIGITS_W-1:0]        = DIGITS_W'(out_digits_reg);
    assign m_axis_tdata[M_TDATA_W-1:DIGITS_W] = EXP_W'(out_exp_reg);
    assign m_axis_tuser                      = out_flags_reg;

    // A zero difference carries no digits, exponent zero and no underflow.
    a_zero_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && out_flags_reg.result_zero) |->
            (out_digits_reg == '0 && out_exp_reg == '0 && !out_flags_reg.exp_underflow))
        else $error("zero result carries digits, exponent or underflow");

    // A nonzero result is normalized: its top digit is never zero.
    a_normalized: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !out_flags_reg.result_zero) |->
            (out_digits_reg[DW-1 -: 4] != 4'd0))
        else $error("nonzero result has a leading zero digit");

    // After an underflow the exponent is zero, or one after a rounding carry.
    a_uflow_exp: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && out_flags_reg.exp_underflow) |->
            (out_exp_reg <= EXP_BITS'(1)))
        else $error("underflowed result has a large exponent");

    // No result word is presented in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire
